// ===== rtl/core/rde_pkg.sv =====
package rde_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int IN_VALUE_W     = 64;
    localparam int RADIX_W        = 6;
    localparam int DIGIT_W        = 6;
    localparam int CHAR_W         = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);
    localparam logic [DIGIT_W-1:0] DIGIT_MAX_DEC = DIGIT_W'(9);
    localparam logic [DIGIT_W-1:0] DIGIT_TEN     = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  CHAR_MINUS    = CHAR_W'(8'h2D);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = CHAR_W'(48);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic feed;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic in_ready;
        logic out_valid;
        logic out_sign;
        logic out_last;
    } port_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(
        input logic [DIGIT_W-1:0] d,
        input logic [CHAR_W-1:0]  letter
    );
        logic [CHAR_W-1:0] ch;
        if (d > DIGIT_MAX_DEC)
            ch = letter + CHAR_W'(d - DIGIT_TEN);
        else
            ch = CHAR_ZERO + CHAR_W'(d);
        return ch;
    endfunction

endpackage

// ===== rtl/core/rde_if.sv =====
interface rde_in_if import rde_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [IN_VALUE_W-1:0]   value;
    logic [RADIX_W-1:0]      radix;
    logic [CHAR_W-1:0]       letter_start;

    modport source (output valid, output value, output radix, output letter_start,
                    input ready);
    modport sink   (input valid, input value, input radix, input letter_start,
                    output ready);
endinterface

interface rde_out_if import rde_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_out;
    logic              last_char;

    modport source (output valid, output char_out, output last_char, input ready);
    modport sink   (input valid, input char_out, input last_char, output ready);
endinterface

// ===== rtl/core/rde_cell.sv =====
module rde_cell
    import rde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [RADIX_W-1:0] radix,
    input  logic               carry_in,
    input  logic               vld_in,
    input  logic [DIGIT_W-1:0] digit_in,
    output logic               carry_out,
    output logic               vld_out,
    output logic [DIGIT_W-1:0] digit_out
);

    logic [DIGIT_W-1:0] digit_reg;
    logic               carry_reg;
    logic               vld_reg;
    logic [DIGIT_W:0]   dbl;
    logic               over;

    // digit*2 + carry, reduced once by the base
    assign dbl  = {digit_reg, carry_in};
    assign over = (dbl >= {1'b0, radix});

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
            digit_reg <= '0;
        else if (ctrl.shift)
            digit_reg <= digit_in;
        else if (vld_in)
            digit_reg <= over ? DIGIT_W'(dbl - {1'b0, radix}) : DIGIT_W'(dbl);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            carry_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            carry_reg <= vld_in & over;
            vld_reg   <= vld_in;
        end
    end

    assign carry_out = carry_reg;
    assign vld_out   = vld_reg;
    assign digit_out = digit_reg;

endmodule

// ===== rtl/core/rde_ctrl.sv =====
module rde_ctrl
    import rde_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic       out_fire,
    input  logic       minus,
    input  logic       top_zero,
    output cell_ctrl_t cell_ctrl,
    output port_ctrl_t port_ctrl
);

    localparam int CNT_W = $clog2(2 * VALUE_BITS);
    localparam int REM_W = $clog2(VALUE_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_FEED = CNT_W'(VALUE_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * VALUE_BITS - 2);
    localparam logic [REM_W-1:0] REM_FULL = REM_W'(VALUE_BITS);
    localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic              minus_reg, minus_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            minus_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            minus_reg <= minus_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        minus_next = minus_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_CONV;
                    cnt_next   = '0;
                    rem_next   = REM_FULL;
                    minus_next = minus;
                end
            end
            ST_CONV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                if (top_zero && (rem_reg != REM_ONE))
                    rem_next = rem_reg - REM_W'(1);
                else
                    state_next = minus_reg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN:
            begin
                if (out_fire)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    rem_next = rem_reg - REM_W'(1);
                    if (rem_reg == REM_ONE)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cell_ctrl           = '0;
        port_ctrl           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                port_ctrl.in_ready = 1'b1;
                cell_ctrl.clear    = in_fire;
            end
            ST_CONV:
            begin
                cell_ctrl.feed = (cnt_reg < CNT_FEED);
            end
            ST_SKIP:
            begin
                cell_ctrl.shift = top_zero && (rem_reg != REM_ONE);
            end
            ST_SIGN:
            begin
                port_ctrl.out_valid = 1'b1;
                port_ctrl.out_sign  = 1'b1;
            end
            ST_EMIT:
            begin
                port_ctrl.out_valid = 1'b1;
                port_ctrl.out_last  = (rem_reg == REM_ONE);
                cell_ctrl.shift     = out_fire;
            end
            default:
            begin
                cell_ctrl = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/radix_digit_emitter_top.sv =====
// Radix digit emitter: prints one integer as ASCII characters.
// number: valid/ready word with value, radix and letter_start. Only the low
//   VALUE_BITS bits of value are used; radix is clamped to 2..36.
// chars: valid/ready word with char_out and last_char, most significant
//   digit first, a leading '-' for negative numbers in base ten only.
// One number is in flight at a time; number.ready is high only while idle.
// Conversion runs through a row of VALUE_BITS digit cells. Value bits enter
//   the bottom cell MSB first, one per cycle, and the carries ripple up the
//   row through a register in each cell.
// Leading zero digits are then shifted out of the top cell, one per cycle,
//   keeping at least one digit. The minus sign, if any, and the digits are
//   then sent as characters.
// A stalled receiver holds the current character; nothing advances until
//   it is taken. After the word flagged last_char, number.ready returns in
//   the next cycle.
// Reset returns the block to idle; a number in progress is dropped.
module radix_digit_emitter_top
    import rde_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    rde_in_if.sink      number,
    rde_out_if.source   chars
);

    cell_ctrl_t               cell_ctrl;
    port_ctrl_t               port_ctrl;
    logic                     in_fire;
    logic                     out_fire;
    logic [VALUE_BITS-1:0]    v_in;
    logic                     neg_in;
    logic [RADIX_W-1:0]       radix_in;
    logic [VALUE_BITS-1:0]    mag_reg;
    logic [RADIX_W-1:0]       radix_reg;
    logic [CHAR_W-1:0]        letter_reg;
    logic [VALUE_BITS:0]      carry_chain;
    logic [VALUE_BITS:0]      vld_chain;
    logic [DIGIT_W-1:0]       digit_chain [VALUE_BITS+1];
    logic [DIGIT_W-1:0]       digit_top;

    assign in_fire  = number.valid && number.ready;
    assign out_fire = chars.valid && chars.ready;

    assign v_in = number.value[VALUE_BITS-1:0];

    always_comb
    begin
        if (number.radix < RADIX_MIN)
            radix_in = RADIX_MIN;
        else if (number.radix > RADIX_MAX)
            radix_in = RADIX_MAX;
        else
            radix_in = number.radix;
    end

    assign neg_in = (radix_in == RADIX_DEC) && v_in[VALUE_BITS-1];

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mag_reg    <= neg_in ? (~v_in + VALUE_BITS'(1)) : v_in;
            radix_reg  <= radix_in;
            letter_reg <= number.letter_start;
        end
        else if (cell_ctrl.feed)
        begin
            mag_reg <= {mag_reg[VALUE_BITS-2:0], 1'b0};
        end
    end

    rde_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .minus     (neg_in),
        .top_zero  (digit_top == '0),
        .cell_ctrl (cell_ctrl),
        .port_ctrl (port_ctrl)
    );

    assign carry_chain[0] = mag_reg[VALUE_BITS-1];
    assign vld_chain[0]   = cell_ctrl.feed;
    assign digit_chain[0] = '0;

    for (genvar k = 0; k < VALUE_BITS; k++)
    begin : g_cell
        rde_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .radix     (radix_reg),
            .carry_in  (carry_chain[k]),
            .vld_in    (vld_chain[k]),
            .digit_in  (digit_chain[k]),
            .carry_out (carry_chain[k+1]),
            .vld_out   (vld_chain[k+1]),
            .digit_out (digit_chain[k+1])
        );
    end

    assign digit_top = digit_chain[VALUE_BITS];

    assign number.ready    = port_ctrl.in_ready;
    assign chars.valid     = port_ctrl.out_valid;
    assign chars.last_char = port_ctrl.out_last;
    assign chars.char_out  = port_ctrl.out_sign ? CHAR_MINUS
                                                : digit_to_char(digit_top, letter_reg);

    // top cell never overflows: the row is wide enough for base two
    a_no_top_carry: assert property (@(posedge clk) disable iff (!rst_n)
        !carry_chain[VALUE_BITS])
        else $error("carry out of top digit cell");

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(number.ready && chars.valid))
        else $error("input ready while output pending");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && !port_ctrl.out_sign) |-> (digit_top < radix_reg))
        else $error("emitted digit not below radix");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && chars.last_char) |=> number.ready)
        else $error("not idle after last character");

    a_stream_busy: assert property (@(posedge clk) disable iff (!rst_n)
        vld_chain[VALUE_BITS] |-> !number.ready)
        else $error("cell stream active while idle");

endmodule
